// ===== rtl/saub_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saub_pkg
// shared types and constants for the straight-alpha under blend unit
// ----------------------------------------------------------------------------
package saub_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned FULL     = 255;
  localparam int unsigned HALF     = FULL / 2;           // rounding offset of den / 255
  localparam int unsigned WGT_W    = 16;                 // a*255, b*(255-a), den
  localparam int unsigned AQ_W     = WGT_W + 1;          // den + 127 and its div-255 sum
  localparam int unsigned PROD_W   = PIX_W + WGT_W;      // colour times weight
  localparam int unsigned NUM_W    = PROD_W + 1;         // 2*num + den
  localparam int unsigned DIV_W    = WGT_W + 1;          // 2*den
  localparam int unsigned Q_W      = PIX_W;              // quotient bits
  localparam int unsigned COLOR_N  = 3;                  // red, green, blue

  typedef struct packed {
    logic [PIX_W-1:0] top_red;
    logic [PIX_W-1:0] top_green;
    logic [PIX_W-1:0] top_blue;
    logic [PIX_W-1:0] top_alpha;
    logic [PIX_W-1:0] under_red;
    logic [PIX_W-1:0] under_green;
    logic [PIX_W-1:0] under_blue;
    logic [PIX_W-1:0] under_alpha;
  } saub_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;
  } saub_out_t;

endpackage

// ===== rtl/straight_alpha_under_blend_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// straight_alpha_under_blend_unit
// porter-duff top-over-under composite of two straight-alpha rgba8 pixels
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle; all 11 register stages move every
//   cycle, the colour lanes run a restoring divider of one quotient bit per stage
// busy is always low; results are strobed once and the receiver cannot stall
// reset (rst_n low, synchronous) clears all stage valid bits; no clearing pass
module straight_alpha_under_blend_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  saub_pkg::saub_in_t  in_data,
  output logic                out_valid,
  output saub_pkg::saub_out_t out_data
);
  import saub_pkg::*;

  // ---------------- stage 1: alpha weights ----------------
  logic                v1_r;
  logic [WGT_W-1:0]    wt_r, wu_r;
  logic [PIX_W-1:0]    top1_r   [COLOR_N];
  logic [PIX_W-1:0]    under1_r [COLOR_N];

  logic [WGT_W-1:0]    wt_nxt, wu_nxt;
  logic [PIX_W-1:0]    inv_a;

  // the pipeline never stalls, so a transaction is taken whenever start is high
  assign busy = 1'b0;

  always_comb begin
    inv_a  = PIX_W'(FULL) - in_data.top_alpha;
    wt_nxt = WGT_W'(in_data.top_alpha) * WGT_W'(FULL);
    wu_nxt = WGT_W'(in_data.under_alpha) * WGT_W'(inv_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    wt_r        <= wt_nxt;
    wu_r        <= wu_nxt;
    top1_r[0]   <= in_data.top_red;
    top1_r[1]   <= in_data.top_green;
    top1_r[2]   <= in_data.top_blue;
    under1_r[0] <= in_data.under_red;
    under1_r[1] <= in_data.under_green;
    under1_r[2] <= in_data.under_blue;
  end

  // ---------------- stage 2: weighted colour products ----------------
  logic                v2_r;
  logic [PROD_W-1:0]   pt_r [COLOR_N];
  logic [PROD_W-1:0]   pu_r [COLOR_N];
  logic [WGT_W-1:0]    den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // den never exceeds 255*255, so the sum fits the weight width
  always_ff @(posedge clk) begin
    for (int c = 0; c < COLOR_N; c++) begin
      pt_r[c] <= PROD_W'(top1_r[c]) * PROD_W'(wt_r);
      pu_r[c] <= PROD_W'(under1_r[c]) * PROD_W'(wu_r);
    end
    den_r <= WGT_W'(wt_r + wu_r);
  end

  // ---------------- stage 3: dividend and divisor per lane ----------------
  // round half up: floor((2*num + den) / (2*den)) for the colour lanes
  // alpha is floor((den + 127) / 255); for y below 255*256 that division
  // is exact as (y + 1 + (y >> 8)) >> 8, so no divider is needed there
  logic [NUM_W-1:0]    n_nxt [COLOR_N];
  logic [DIV_W-1:0]    d_nxt [COLOR_N];
  logic [AQ_W-1:0]     aq_y;
  logic [AQ_W-1:0]     aq_s;
  logic [PIX_W-1:0]    alpha_nxt;

  always_comb begin
    for (int c = 0; c < COLOR_N; c++) begin
      n_nxt[c] = ((NUM_W'(pt_r[c]) + NUM_W'(pu_r[c])) << 1) + NUM_W'(den_r);
      d_nxt[c] = DIV_W'(den_r) << 1;
    end
    aq_y      = AQ_W'(den_r) + AQ_W'(HALF);
    aq_s      = aq_y + AQ_W'(1) + (aq_y >> PIX_W);
    alpha_nxt = PIX_W'(aq_s >> PIX_W);
  end

  // divider pipeline registers: index 0 is loaded here, index Q_W holds the
  // finished quotients; alpha rides along beside them
  logic                dv_r  [Q_W+1];
  logic                zr_r  [Q_W+1];
  logic [PIX_W-1:0]    al_r  [Q_W+1];
  logic [NUM_W-1:0]    rem_r [Q_W+1][COLOR_N];
  logic [DIV_W-1:0]    dd_r  [Q_W+1][COLOR_N];
  logic [Q_W-1:0]      q_r   [Q_W+1][COLOR_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v2_r;
    end
  end

  // both alphas zero is the only way den can be zero; that result is all zero
  always_ff @(posedge clk) begin
    zr_r[0] <= (den_r == '0);
    al_r[0] <= alpha_nxt;
    for (int l = 0; l < COLOR_N; l++) begin
      rem_r[0][l] <= n_nxt[l];
      dd_r[0][l]  <= d_nxt[l];
      q_r[0][l]   <= '0;
    end
  end

  // ---------------- stages 4..11: one quotient bit per stage ----------------
  // the quotient is known to stay below 256, so the first trial subtracts
  // the divisor shifted by seven
  for (genvar s = 0; s < Q_W; s++) begin : g_div
    localparam int unsigned SH = Q_W - 1 - s;

    logic [NUM_W-1:0] rem_nxt [COLOR_N];
    logic [Q_W-1:0]   q_nxt   [COLOR_N];

    always_comb begin
      logic [NUM_W-1:0] trial;
      for (int l = 0; l < COLOR_N; l++) begin
        trial = NUM_W'(dd_r[s][l]) << SH;
        if (rem_r[s][l] >= trial) begin
          rem_nxt[l] = rem_r[s][l] - trial;
          q_nxt[l]   = q_r[s][l] | Q_W'(1 << SH);
        end else begin
          rem_nxt[l] = rem_r[s][l];
          q_nxt[l]   = q_r[s][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else begin
        dv_r[s+1] <= dv_r[s];
      end
    end

    always_ff @(posedge clk) begin
      zr_r[s+1] <= zr_r[s];
      al_r[s+1] <= al_r[s];
      for (int l = 0; l < COLOR_N; l++) begin
        rem_r[s+1][l] <= rem_nxt[l];
        dd_r[s+1][l]  <= dd_r[s][l];
        q_r[s+1][l]   <= q_nxt[l];
      end
    end
  end

  // ---------------- result strobe ----------------
  // the zero-coverage case forces every field to zero
  assign out_valid          = dv_r[Q_W];
  assign out_data.out_red   = zr_r[Q_W] ? '0 : q_r[Q_W][0];
  assign out_data.out_green = zr_r[Q_W] ? '0 : q_r[Q_W][1];
  assign out_data.out_blue  = zr_r[Q_W] ? '0 : q_r[Q_W][2];
  assign out_data.out_alpha = zr_r[Q_W] ? '0 : al_r[Q_W];

endmodule
